### rtl/core/hps_pkg.sv
// Shared types and constants for the haptic pattern sequencer.
`timescale 1ns / 1ps
`default_nettype none
package hps_pkg;

   localparam int QUEUE_DEPTH = 256;
   localparam int MAX_STEP_MS = 10000;

   localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int DUR_W   = $clog2(MAX_STEP_MS + 1);
   localparam int TIME_W  = 22;
   localparam int STR_W   = 8;
   localparam int IN_DUR_W = 16;

   localparam logic [TIME_W-1:0]  TIME_MAX = {TIME_W{1'b1}};
   localparam logic [COUNT_W-1:0] DEPTH_COUNT = COUNT_W'(QUEUE_DEPTH);
   localparam logic [DUR_W-1:0]   MAX_DUR = DUR_W'(MAX_STEP_MS);

   typedef enum logic [2:0] {
      ACT_ENQ_RAW   = 3'd0,
      ACT_ENQ_ONOFF = 3'd1,
      ACT_START     = 3'd2,
      ACT_CLEAR     = 3'd3,
      ACT_SET_OWNER = 3'd4,
      ACT_CLR_OWNER = 3'd5,
      ACT_TICK      = 3'd6,
      ACT_NOP       = 3'd7
   } action_type;

   typedef enum logic {
      REG_DEFAULT_STRENGTH = 1'b0,
      REG_SERVICE_ENABLED  = 1'b1
   } reg_index_type;

   // one queued step
   typedef struct packed {
      logic [DUR_W-1:0]        dur;
      logic signed [STR_W-1:0] str;
   } step_type;

   // queue control from the sequencer to the cell row
   typedef struct packed {
      logic             push;
      logic             pop;
      logic [PTR_W-1:0] wr_ptr;
   } q_ctrl_type;

endpackage
`default_nettype wire

### rtl/core/haptic_pattern_sequencer.sv
// Top level of the haptic pattern sequencer: command decode, timing and motor drive.
//
// Usage: a command is taken on a clock edge with start high (busy stays low,
// every command completes before the next). The command fields sit on the req_
// ports. Exactly one result per command appears on the rsp_ ports in the next
// cycle, marked by rsp_valid for a single cycle; there is no back pressure,
// so the receiver must take it then. Throughput is one command per cycle.
// Steps live in a row of cells; cell 0 is always the head and a pop moves
// the whole row one place toward it in the same cycle, so no memory port
// limits the rate. Ticks (one per millisecond) advance the elapsed count
// against the running deadline and pop at most one step per tick.
// Registers are written through csr_we/csr_index/csr_wdata; the user must do so only
// while no command is in flight, as the block does not enforce it. Synchronous reset
// clears the control state, sets the default strength to 100 and enables the service;
// queued step contents are not cleared, since only occupied cells are ever read.
`timescale 1ns / 1ps
`default_nettype none
module haptic_pattern_sequencer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [2:0]  req_action,
   input  wire logic [15:0] req_step_duration,
   input  wire logic signed [7:0] req_step_strength,
   input  wire logic        req_step_on,
   input  wire logic [2:0]  req_owner,
   input  wire logic        req_caller_is_app,
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [7:0]  csr_wdata,
   output logic             rsp_valid,
   output logic             rsp_accepted,
   output logic signed [7:0] rsp_motor_strength,
   output logic             rsp_motor_on,
   output logic             rsp_pattern_active,
   output logic [2:0]       rsp_current_owner,
   output logic [8:0]       rsp_queued_steps
);

   localparam int CW = hps_pkg::COUNT_W;
   localparam int TW = hps_pkg::TIME_W;
   localparam int SW = hps_pkg::STR_W;

   logic [CW-1:0]        count_ff, count_in;
   logic                 playing_ff, playing_in;
   logic [2:0]           owner_ff, owner_in;
   logic [2:0]           pending_ff, pending_in;
   logic signed [SW-1:0] drive_ff, drive_in;
   logic [TW-1:0]        deadline_ff, deadline_in;
   logic [TW-1:0]        elapsed_ff, elapsed_in;
   logic signed [SW-1:0] dflt_ff, dflt_in;
   logic                 en_ff, en_in;
   logic                 rsp_valid_ff;
   logic                 rsp_accepted_ff, accepted;

   hps_pkg::q_ctrl_type  qctrl;
   hps_pkg::step_type    push_step, head_step, next_step;
   hps_pkg::action_type  act;

   logic                 take;
   logic [TW-1:0]        elapsed_inc;
   logic [TW:0]          dl_sum;
   logic [CW-1:0]        count_dec;

   assign busy = 1'b0;
   assign take = start && !busy;
   assign act  = hps_pkg::action_type'(req_action);

   hps_chain u_chain (
      .clock     (clock),
      .ctrl      (qctrl),
      .push_step (push_step),
      .head_step (head_step),
      .next_step (next_step)
   );

   always_comb begin
      push_step.dur = (req_step_duration > hps_pkg::IN_DUR_W'(hps_pkg::MAX_STEP_MS))
                      ? hps_pkg::MAX_DUR : req_step_duration[hps_pkg::DUR_W-1:0];
      if (act == hps_pkg::ACT_ENQ_ONOFF) begin
         push_step.str = req_step_on ? dflt_ff : '0;
      end else begin
         push_step.str = req_step_strength;
      end
   end

   assign elapsed_inc = (elapsed_ff < hps_pkg::TIME_MAX) ? elapsed_ff + 1'b1 : elapsed_ff;
   assign dl_sum      = {1'b0, deadline_ff} + (TW + 1)'(next_step.dur);
   assign count_dec   = count_ff - 1'b1;

   always_comb begin
      count_in    = count_ff;
      playing_in  = playing_ff;
      owner_in    = owner_ff;
      pending_in  = pending_ff;
      drive_in    = drive_ff;
      deadline_in = deadline_ff;
      elapsed_in  = elapsed_ff;
      dflt_in     = dflt_ff;
      en_in       = en_ff;
      accepted    = 1'b0;
      qctrl.push  = 1'b0;
      qctrl.pop   = 1'b0;
      qctrl.wr_ptr = count_ff[hps_pkg::PTR_W-1:0];

      if (take) begin
         case (act)
            hps_pkg::ACT_ENQ_RAW, hps_pkg::ACT_ENQ_ONOFF: begin
               if (!playing_ff && (count_ff < hps_pkg::DEPTH_COUNT)) begin
                  accepted   = 1'b1;
                  qctrl.push = 1'b1;
                  count_in   = count_ff + 1'b1;
                  if (count_ff == '0) begin
                     // owner latches at the first step of a pattern
                     if (pending_ff != 3'd0) begin
                        owner_in = pending_ff;
                     end else begin
                        owner_in = {2'b00, req_caller_is_app};
                     end
                     pending_in = 3'd0;
                  end
               end
            end
            hps_pkg::ACT_START: begin
               if ((count_ff != '0) && !playing_ff) begin
                  elapsed_in  = '0;
                  deadline_in = TW'(head_step.dur);
                  playing_in  = 1'b1;
                  if (en_ff) begin
                     drive_in = head_step.str;
                  end
               end
            end
            hps_pkg::ACT_CLEAR: begin
               count_in   = '0;
               playing_in = 1'b0;
               owner_in   = 3'd0;
               if (en_ff) begin
                  drive_in = '0;
               end
            end
            hps_pkg::ACT_SET_OWNER: begin
               pending_in = req_owner;
            end
            hps_pkg::ACT_CLR_OWNER: begin
               if (owner_ff == req_owner) begin
                  count_in   = '0;
                  playing_in = 1'b0;
                  owner_in   = 3'd0;
                  if (en_ff) begin
                     drive_in = '0;
                  end
               end
            end
            hps_pkg::ACT_TICK: begin
               if (playing_ff && (count_ff != '0)) begin
                  elapsed_in = elapsed_inc;
                  if (elapsed_inc >= deadline_ff) begin
                     qctrl.pop = 1'b1;
                     count_in  = count_dec;
                     if (count_dec != '0) begin
                        // new head is in cell 1 until the shift lands
                        if (en_ff) begin
                           drive_in = next_step.str;
                        end
                        deadline_in = dl_sum[TW] ? hps_pkg::TIME_MAX : dl_sum[TW-1:0];
                     end else begin
                        playing_in = 1'b0;
                        owner_in   = 3'd0;
                        if (en_ff) begin
                           drive_in = '0;
                        end
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end

      if (csr_we) begin
         case (hps_pkg::reg_index_type'(csr_index))
            hps_pkg::REG_DEFAULT_STRENGTH: begin
               dflt_in = csr_wdata;
            end
            hps_pkg::REG_SERVICE_ENABLED: begin
               en_in = csr_wdata[0];
               if (csr_wdata[0] != en_ff && en_ff) begin
                  drive_in = '0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         playing_ff   <= 1'b0;
         owner_ff     <= 3'd0;
         pending_ff   <= 3'd0;
         drive_ff     <= '0;
         deadline_ff  <= '0;
         elapsed_ff   <= '0;
         dflt_ff      <= SW'(100);
         en_ff        <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         playing_ff   <= playing_in;
         owner_ff     <= owner_in;
         pending_ff   <= pending_in;
         drive_ff     <= drive_in;
         deadline_ff  <= deadline_in;
         elapsed_ff   <= elapsed_in;
         dflt_ff      <= dflt_in;
         en_ff        <= en_in;
         rsp_valid_ff <= take;
      end
   end

   always_ff @(posedge clock) begin
      rsp_accepted_ff <= accepted;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_accepted       = rsp_accepted_ff;
   assign rsp_motor_strength = drive_ff;
   assign rsp_motor_on       = en_ff && (drive_ff != '0);
   assign rsp_pattern_active = playing_ff;
   assign rsp_current_owner  = owner_ff;
   assign rsp_queued_steps   = 9'(count_ff);

endmodule
`default_nettype wire

### rtl/core/hps_cell.sv
// One queue cell: holds a step, loads a new one or takes its neighbor's on a pop.
`timescale 1ns / 1ps
`default_nettype none
module hps_cell (
   input  wire logic              clock,
   input  wire logic              load,
   input  wire logic              shift,
   input  wire hps_pkg::step_type load_step,
   input  wire hps_pkg::step_type neighbor_step,
   output hps_pkg::step_type      step
);

   hps_pkg::step_type step_ff;

   always_ff @(posedge clock) begin
      if (shift) begin
         step_ff <= neighbor_step;
      end else if (load) begin
         step_ff <= load_step;
      end
   end

   assign step = step_ff;

endmodule
`default_nettype wire

### rtl/core/hps_chain.sv
// Row of queue cells; the head always sits in cell 0 and a pop shifts the row down.
`timescale 1ns / 1ps
`default_nettype none
module hps_chain (
   input  wire logic                clock,
   input  wire hps_pkg::q_ctrl_type ctrl,
   input  wire hps_pkg::step_type   push_step,
   output hps_pkg::step_type        head_step,
   output hps_pkg::step_type        next_step
);

   hps_pkg::step_type cell_q [hps_pkg::QUEUE_DEPTH];

   genvar i;
   generate
      for (i = 0; i < hps_pkg::QUEUE_DEPTH; i++) begin : g_cell
         hps_pkg::step_type nb;
         if (i == hps_pkg::QUEUE_DEPTH - 1) begin : g_last
            assign nb = cell_q[i];
         end else begin : g_mid
            assign nb = cell_q[i+1];
         end
         hps_cell u_cell (
            .clock         (clock),
            .load          (ctrl.push && (ctrl.wr_ptr == hps_pkg::PTR_W'(i))),
            .shift         (ctrl.pop),
            .load_step     (push_step),
            .neighbor_step (nb),
            .step          (cell_q[i])
         );
      end
      if (hps_pkg::QUEUE_DEPTH > 1) begin : g_next
         assign next_step = cell_q[1];
      end else begin : g_next_one
         assign next_step = cell_q[0];
      end
   endgenerate

   assign head_step = cell_q[0];

endmodule
`default_nettype wire

### test/hps_motor_checker.sv
// Checker for the haptic pattern sequencer: predicts each result from the command stream.
`timescale 1ns / 1ps
module hps_motor_checker
   import hps_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  logic [2:0]        req_action,
   input  logic [15:0]       req_step_duration,
   input  logic signed [7:0] req_step_strength,
   input  logic              req_step_on,
   input  logic [2:0]        req_owner,
   input  logic              req_caller_is_app,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [7:0]        csr_wdata,
   input  logic              rsp_valid,
   input  logic              rsp_accepted,
   input  logic signed [7:0] rsp_motor_strength,
   input  logic              rsp_motor_on,
   input  logic              rsp_pattern_active,
   input  logic [2:0]        rsp_current_owner,
   input  logic [8:0]        rsp_queued_steps,
   output int                fail_count,
   output int                pending_count,
   output int                checked_count
);

   typedef struct packed {
      logic              accepted;
      logic signed [7:0] strength;
      logic              motor_on;
      logic              active;
      logic [2:0]        owner;
      logic [8:0]        steps;
   } motor_status_type;

   motor_status_type expected_status_q[$];

   // predicted block state
   logic [DUR_W-1:0]        step_dur[QUEUE_DEPTH];
   logic signed [STR_W-1:0] step_str[QUEUE_DEPTH];
   logic [PTR_W-1:0]        head;
   logic [COUNT_W-1:0]      count;
   logic                    playing;
   logic [2:0]              owner;
   logic [2:0]              pending_owner;
   logic signed [STR_W-1:0] drive_str;
   logic [TIME_W-1:0]       deadline;
   logic [TIME_W-1:0]       elapsed;
   logic signed [STR_W-1:0] dflt_strength;
   logic                    svc_enabled;

   task automatic reset_state();
      head          = '0;
      count         = '0;
      playing       = 1'b0;
      owner         = 3'd0;
      pending_owner = 3'd0;
      drive_str     = '0;
      deadline      = '0;
      elapsed       = '0;
      dflt_strength = 8'sd100;
      svc_enabled   = 1'b1;
   endtask

   function automatic void set_drive(input logic signed [STR_W-1:0] s);
      if (svc_enabled) begin
         drive_str = s;
      end
   endfunction

   function automatic void add_deadline(input logic [DUR_W-1:0] d);
      logic [TIME_W:0] sum;
      sum = {1'b0, deadline} + (TIME_W+1)'(d);
      deadline = (sum > {1'b0, TIME_MAX}) ? TIME_MAX : sum[TIME_W-1:0];
   endfunction

   function automatic void stop_pattern();
      head    = '0;
      count   = '0;
      set_drive('0);
      playing = 1'b0;
      owner   = 3'd0;
   endfunction

   function automatic logic push_step(input logic [15:0] dur,
                                      input logic signed [7:0] str,
                                      input logic app);
      logic [15:0]      d;
      logic [PTR_W-1:0] slot;
      if (playing || count >= DEPTH_COUNT) begin
         return 1'b0;
      end
      d = (dur > 16'(MAX_STEP_MS)) ? 16'(MAX_STEP_MS) : dur;
      if (count == 0) begin
         if (pending_owner != 3'd0) begin
            owner = pending_owner;
         end else begin
            owner = app ? 3'd1 : 3'd0;
         end
         pending_owner = 3'd0;
      end
      slot = head + count[PTR_W-1:0];
      step_dur[slot] = d[DUR_W-1:0];
      step_str[slot] = str;
      count = count + 1'b1;
      return 1'b1;
   endfunction

   task automatic apply_register(input logic idx, input logic [7:0] val);
      if (idx == REG_DEFAULT_STRENGTH) begin
         dflt_strength = val;
      end else if (val[0] != svc_enabled) begin
         // switching the service off forces the motor off first
         set_drive('0);
         svc_enabled = val[0];
      end
   endtask

   function automatic motor_status_type run_command();
      motor_status_type st;
      logic             acc;
      acc = 1'b0;
      case (action_type'(req_action))
         ACT_ENQ_RAW: begin
            acc = push_step(req_step_duration, req_step_strength, req_caller_is_app);
         end
         ACT_ENQ_ONOFF: begin
            acc = push_step(req_step_duration, req_step_on ? dflt_strength : 8'sd0,
                            req_caller_is_app);
         end
         ACT_START: begin
            if (count != 0 && !playing) begin
               elapsed  = '0;
               deadline = '0;
               set_drive(step_str[head]);
               playing = 1'b1;
               add_deadline(step_dur[head]);
            end
         end
         ACT_CLEAR: begin
            stop_pattern();
         end
         ACT_SET_OWNER: begin
            pending_owner = req_owner;
         end
         ACT_CLR_OWNER: begin
            if (owner == req_owner) begin
               stop_pattern();
            end
         end
         ACT_TICK: begin
            if (playing && count != 0) begin
               if (elapsed < TIME_MAX) begin
                  elapsed = elapsed + 1'b1;
               end
               // at most one pop per tick
               if (elapsed >= deadline) begin
                  head  = head + 1'b1;
                  count = count - 1'b1;
                  if (count != 0) begin
                     set_drive(step_str[head]);
                     add_deadline(step_dur[head]);
                  end else begin
                     head = '0;
                     set_drive('0);
                     playing = 1'b0;
                     owner   = 3'd0;
                  end
               end
            end
         end
         default: begin
         end
      endcase
      st.accepted = acc;
      st.strength = drive_str;
      st.motor_on = svc_enabled && (drive_str != 0);
      st.active   = playing;
      st.owner    = owner;
      st.steps    = 9'(count);
      return st;
   endfunction

   always @(posedge clock) begin
      motor_status_type want;
      motor_status_type seen;
      if (reset) begin
         reset_state();
         expected_status_q.delete();
         fail_count    = 0;
         pending_count = 0;
         checked_count = 0;
      end else begin
         if (csr_we) begin
            apply_register(csr_index, csr_wdata);
         end
         if (start && !busy) begin
            expected_status_q.push_back(run_command());
         end
         if (rsp_valid) begin
            seen = {rsp_accepted, rsp_motor_strength, rsp_motor_on, rsp_pattern_active,
                    rsp_current_owner, rsp_queued_steps};
            if (expected_status_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $display("unexpected result at %0t: accepted=%0d strength=%0d",
                           $realtime, seen.accepted, seen.strength);
               end
            end else begin
               want = expected_status_q.pop_front();
               checked_count++;
               if (seen.accepted !== want.accepted || seen.strength !== want.strength ||
                   seen.motor_on !== want.motor_on || seen.active !== want.active ||
                   seen.owner !== want.owner || seen.steps !== want.steps) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("mismatch at %0t: exp acc=%0d str=%0d on=%0d act=%0d own=%0d n=%0d",
                              $realtime, want.accepted, want.strength, want.motor_on,
                              want.active, want.owner, want.steps);
                     $display("                 act acc=%0d str=%0d on=%0d act=%0d own=%0d n=%0d",
                              seen.accepted, seen.strength, seen.motor_on,
                              seen.active, seen.owner, seen.steps);
                  end
               end
            end
         end
         pending_count = expected_status_q.size();
      end
   end

endmodule

### test/tb.sv
// Testbench top for the haptic pattern sequencer: command stimulus, register phases, verdict.
`timescale 1ns / 1ps
module tb;
   import hps_pkg::*;

   localparam int RANDOM_CMDS = 1350;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   action_type        req_action;
   logic [15:0]       req_step_duration;
   logic signed [7:0] req_step_strength;
   logic              req_step_on;
   logic [2:0]        req_owner;
   logic              req_caller_is_app;
   logic              csr_we;
   reg_index_type     csr_index;
   logic [7:0]        csr_wdata;
   logic              rsp_valid;
   logic              rsp_accepted;
   logic signed [7:0] rsp_motor_strength;
   logic              rsp_motor_on;
   logic              rsp_pattern_active;
   logic [2:0]        rsp_current_owner;
   logic [8:0]        rsp_queued_steps;

   int fail_count;
   int pending_count;
   int checked_count;
   int sent;
   int next_cfg;
   logic svc_on;

   haptic_pattern_sequencer DUT (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_action         (req_action),
      .req_step_duration  (req_step_duration),
      .req_step_strength  (req_step_strength),
      .req_step_on        (req_step_on),
      .req_owner          (req_owner),
      .req_caller_is_app  (req_caller_is_app),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .rsp_valid          (rsp_valid),
      .rsp_accepted       (rsp_accepted),
      .rsp_motor_strength (rsp_motor_strength),
      .rsp_motor_on       (rsp_motor_on),
      .rsp_pattern_active (rsp_pattern_active),
      .rsp_current_owner  (rsp_current_owner),
      .rsp_queued_steps   (rsp_queued_steps)
   );

   hps_motor_checker checker_i (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_action         (req_action),
      .req_step_duration  (req_step_duration),
      .req_step_strength  (req_step_strength),
      .req_step_on        (req_step_on),
      .req_owner          (req_owner),
      .req_caller_is_app  (req_caller_is_app),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .rsp_valid          (rsp_valid),
      .rsp_accepted       (rsp_accepted),
      .rsp_motor_strength (rsp_motor_strength),
      .rsp_motor_on       (rsp_motor_on),
      .rsp_pattern_active (rsp_pattern_active),
      .rsp_current_owner  (rsp_current_owner),
      .rsp_queued_steps   (rsp_queued_steps),
      .fail_count         (fail_count),
      .pending_count      (pending_count),
      .checked_count      (checked_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

   function automatic logic signed [7:0] rand_strength();
      int v;
      v = $urandom_range(200);
      return 8'(v - 100);
   endfunction

   // one command transfer; called at a rising edge, returns at the accepting edge
   task automatic issue(input action_type act, input logic [15:0] dur,
                        input logic signed [7:0] str, input logic on,
                        input logic [2:0] own, input logic app);
      // quiet stretch with no sender gaps
      if (!(sent >= 500 && sent < 800) && $urandom_range(99) < 6) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_action        <= act;
      req_step_duration <= dur;
      req_step_strength <= str;
      req_step_on       <= on;
      req_owner         <= own;
      req_caller_is_app <= app;
      start             <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      sent++;
   endtask

   // command whose unused fields are random
   task automatic cmd(input action_type act);
      issue(act, 16'($urandom_range(65535)), rand_strength(), 1'($urandom_range(1)),
            3'($urandom_range(7)), 1'($urandom_range(1)));
   endtask

   task automatic enqueue_step(input logic [15:0] dur);
      if ($urandom_range(1)) begin
         issue(ACT_ENQ_RAW, dur, rand_strength(), 1'($urandom_range(1)),
               3'($urandom_range(7)), 1'($urandom_range(1)));
      end else begin
         issue(ACT_ENQ_ONOFF, dur, rand_strength(), 1'($urandom_range(1)),
               3'($urandom_range(7)), 1'($urandom_range(1)));
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      do @(negedge clock); while (pending_count != 0);
      @(posedge clock);
   endtask

   task automatic write_reg(input reg_index_type idx, input logic [7:0] val);
      drain();
      csr_index <= idx;
      csr_wdata <= val;
      csr_we    <= 1'b1;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == REG_SERVICE_ENABLED) begin
         svc_on = val[0];
      end
   endtask

   task automatic config_phase();
      case ($urandom_range(3))
         0:       write_reg(REG_DEFAULT_STRENGTH, 8'sd100);
         1:       write_reg(REG_DEFAULT_STRENGTH, -8'sd100);
         2:       write_reg(REG_DEFAULT_STRENGTH, 8'd0);
         default: write_reg(REG_DEFAULT_STRENGTH, rand_strength());
      endcase
      write_reg(REG_SERVICE_ENABLED, {7'($urandom_range(127)), ($urandom_range(3) != 0)});
   endtask

   task automatic play_pattern();
      int n;
      int total;
      int ticks;
      logic [15:0] d;
      logic long_steps;
      n = $urandom_range(1, 8);
      total = 0;
      long_steps = ($urandom_range(9) == 0);
      if ($urandom_range(4) != 0) begin
         cmd(ACT_CLEAR);
      end
      if ($urandom_range(2) == 0) begin
         cmd(ACT_SET_OWNER);
      end
      for (int i = 0; i < n; i++) begin
         d = long_steps ? 16'($urandom_range(65535)) : 16'($urandom_range(4));
         enqueue_step(d);
         total += (d > 16'(MAX_STEP_MS)) ? MAX_STEP_MS : int'(d);
      end
      cmd(ACT_START);
      if (long_steps) begin
         repeat ($urandom_range(1, 6)) cmd(ACT_TICK);
         if ($urandom_range(1)) begin
            cmd(ACT_CLR_OWNER);
         end
         cmd(ACT_CLEAR);
      end else begin
         ticks = total + n + 1;
         for (int t = 0; t < ticks; t++) begin
            if ($urandom_range(99) < 5) begin
               cmd(action_type'($urandom_range(7)));
            end
            if ($urandom_range(99) < 2) begin
               // motor enable flips while the pattern plays
               write_reg(REG_SERVICE_ENABLED, {7'($urandom_range(127)), ~svc_on});
            end
            cmd(ACT_TICK);
         end
      end
   endtask

   initial begin
      reset             = 1'b1;
      start             = 1'b0;
      req_action        = ACT_NOP;
      req_step_duration = '0;
      req_step_strength = '0;
      req_step_on       = 1'b0;
      req_owner         = 3'd0;
      req_caller_is_app = 1'b0;
      csr_we            = 1'b0;
      csr_index         = REG_DEFAULT_STRENGTH;
      csr_wdata         = '0;
      sent              = 0;
      svc_on            = 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: idle commands, ownership, zero-length and clamped steps
      cmd(ACT_TICK);
      cmd(ACT_START);
      cmd(ACT_NOP);
      issue(ACT_CLR_OWNER, 16'd0, 8'sd0, 1'b0, 3'd0, 1'b0);
      issue(ACT_SET_OWNER, 16'd0, 8'sd0, 1'b0, 3'd5, 1'b0);
      issue(ACT_ENQ_ONOFF, 16'd0, -8'sd100, 1'b1, 3'd7, 1'b1);
      issue(ACT_ENQ_RAW, 16'd1, 8'sd100, 1'b0, 3'd2, 1'b0);
      issue(ACT_ENQ_ONOFF, 16'd2, 8'sd55, 1'b0, 3'd1, 1'b1);
      issue(ACT_ENQ_RAW, 16'hFFFF, -8'sd100, 1'b1, 3'd0, 1'b1);
      cmd(ACT_START);
      cmd(ACT_ENQ_RAW);
      cmd(ACT_START);
      repeat (3) cmd(ACT_TICK);
      issue(ACT_CLR_OWNER, 16'd0, 8'sd0, 1'b0, 3'd2, 1'b0);
      write_reg(REG_SERVICE_ENABLED, 8'h00);
      cmd(ACT_TICK);
      write_reg(REG_SERVICE_ENABLED, 8'h01);
      issue(ACT_CLR_OWNER, 16'd0, 8'sd0, 1'b0, 3'd5, 1'b0);
      write_reg(REG_DEFAULT_STRENGTH, -8'sd100);
      issue(ACT_ENQ_ONOFF, 16'd0, 8'sd0, 1'b1, 3'd3, 1'b1);
      issue(ACT_ENQ_RAW, 16'd10000, 8'sd1, 1'b0, 3'd4, 1'b0);
      cmd(ACT_START);
      cmd(ACT_TICK);
      cmd(ACT_CLEAR);
      issue(ACT_ENQ_ONOFF, 16'd1, 8'sd0, 1'b1, 3'd6, 1'b0);
      cmd(ACT_START);
      repeat (2) cmd(ACT_TICK);

      // fill the queue to the last slot, one more is refused, then play it out
      cmd(ACT_CLEAR);
      repeat (QUEUE_DEPTH + 1) enqueue_step(16'd0);
      cmd(ACT_START);
      repeat (QUEUE_DEPTH + 2) cmd(ACT_TICK);

      next_cfg = sent;
      while (sent < RANDOM_CMDS - 25) begin
         if (sent >= next_cfg) begin
            config_phase();
            next_cfg = sent + $urandom_range(80, 200);
         end
         if ($urandom_range(99) < 75) begin
            play_pattern();
         end else begin
            repeat ($urandom_range(1, 12)) cmd(action_type'($urandom_range(7)));
         end
      end

      // clamped step ahead of a short one; a few ticks stay inside the first step
      write_reg(REG_SERVICE_ENABLED, 8'h01);
      cmd(ACT_CLEAR);
      issue(ACT_ENQ_RAW, 16'hFFFF, 8'sd77, 1'b0, 3'd0, 1'b1);
      issue(ACT_ENQ_RAW, 16'd0, -8'sd5, 1'b0, 3'd0, 1'b0);
      cmd(ACT_START);
      repeat (8) cmd(ACT_TICK);
      cmd(ACT_CLEAR);

      drain();
      repeat (4) @(posedge clock);
      $display("Ran %0d commands with %0d results checked: directed cases, full queue,",
               sent, checked_count);
      $display("random patterns with owner, clear and motor enable changes, clamped steps.");
      if (fail_count == 0 && pending_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
